// File: rtl/swgc_pkg.sv
// swgc_pkg: shared types and constants for the sliding-window gc fraction unit
// used by swgc_front, swgc_fifo, swgc_back and the top level
package swgc_pkg;

    // base class codes
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_AT   = 2'd1;
    localparam logic [1:0] CLS_GC   = 2'd2;

    localparam int          LINE_DEPTH = 64;
    localparam int          LINE_AW    = 6;
    localparam logic [15:0] HALF_LEVEL = 16'd16384;

    // one job handed from front to back: window and total counts and how often to repeat the result
    typedef struct packed {
        logic [6:0]  win_gc;
        logic [6:0]  win_at;
        logic [5:0]  rep;
        logic        last;
        logic [31:0] tot_gc;
        logic [31:0] tot_at;
    } job_t;

    function automatic logic [1:0] classify(input logic [7:0] ch);
        logic [1:0] c;
        c = CLS_NONE;
        if (ch == 8'h43 || ch == 8'h63 || ch == 8'h47 || ch == 8'h67) c = CLS_GC;
        else if (ch == 8'h41 || ch == 8'h61 || ch == 8'h54 || ch == 8'h74) c = CLS_AT;
        return c;
    endfunction

endpackage

// File: rtl/swgc_fifo.sv
// swgc_fifo: short job queue between the front and back parts
// depends on swgc_pkg (job_t)
module swgc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  swgc_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output swgc_pkg::job_t dout,
    output logic          empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    swgc_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

// File: rtl/swgc_div.sv
// swgc_div: radix-2 restoring divider, floor(num * 2^15 / den) for num <= den
// standalone, one quotient bit per cycle
module swgc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [32:0] den,
    output logic        done,
    output logic [15:0] quo
);
    logic [33:0] rem_reg;
    logic [32:0] den_reg;
    logic [15:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic        ge;
    logic [33:0] rem_sub;

    assign ge      = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
    assign done    = done_reg;
    assign quo     = q_reg;

    // datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rem_reg <= {2'b00, num};
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= {rem_sub[32:0], 1'b0};
            q_reg   <= {q_reg[14:0], ge};
        end
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: rtl/swgc_front.sv
// swgc_front: accepts bases, keeps the class ring and counts, queues jobs
// depends on swgc_pkg (classify, job_t, class codes)
module swgc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [4:0]     cfg_wr_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_base,
    input  logic           in_last,
    output logic           job_push,
    output swgc_pkg::job_t job,
    input  logic           job_full
);
    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_UPD  = 2'b10
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [4:0]  half_reg;
    logic [31:0] seen_reg, tgc_reg, tat_reg;
    logic [6:0]  wgc_reg, wat_reg;
    logic [1:0]  cls_reg, old_reg;
    logic        last_reg;
    logic [1:0]  line_mem [swgc_pkg::LINE_DEPTH];

    logic [5:0]  win;
    logic [31:0] n;
    logic        n_lt_w, n_eq_w, n_gt_w, inc_gc, inc_at, dec_gc, dec_at;
    logic [6:0]  wgc_new, wat_new;
    logic [5:0]  rep;
    logic        go;

    assign win     = {half_reg, 1'b1};
    assign in_ready = (state_reg == F_IDLE);
    assign n       = seen_reg + 32'd1;
    assign n_lt_w  = (n < {26'd0, win});
    assign n_eq_w  = (n == {26'd0, win});
    assign n_gt_w  = !n_lt_w && !n_eq_w;
    assign inc_gc  = (cls_reg == swgc_pkg::CLS_GC);
    assign inc_at  = (cls_reg == swgc_pkg::CLS_AT);
    assign dec_gc  = n_gt_w && (old_reg == swgc_pkg::CLS_GC);
    assign dec_at  = n_gt_w && (old_reg == swgc_pkg::CLS_AT);
    assign wgc_new = wgc_reg + 7'(inc_gc) - 7'(dec_gc);
    assign wat_new = wat_reg + 7'(inc_at) - 7'(dec_at);

    // results caused by this base
    always_comb begin
        if (n_lt_w) begin
            rep = last_reg ? n[5:0] : 6'd0;
        end else begin
            rep = (n_eq_w ? ({1'b0, half_reg} + 6'd1) : 6'd1)
                + (last_reg ? {1'b0, half_reg} : 6'd0);
        end
    end

    assign go       = (state_reg == F_UPD) && !(rep != 6'd0 && job_full);
    assign job_push = go && (rep != 6'd0);
    assign job.win_gc = wgc_new;
    assign job.win_at = wat_new;
    assign job.rep    = rep;
    assign job.last   = last_reg;
    assign job.tot_gc = tgc_reg + 32'(inc_gc);
    assign job.tot_at = tat_reg + 32'(inc_at);

    // class ring: write new class, read the one leaving the window
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            line_mem[seen_reg[swgc_pkg::LINE_AW-1:0]] <= swgc_pkg::classify(in_base);
            old_reg <= line_mem[seen_reg[swgc_pkg::LINE_AW-1:0] - win];
            cls_reg <= swgc_pkg::classify(in_base);
            last_reg <= in_last;
        end
    end

    // state sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (in_valid) state_next = F_UPD;
            F_UPD:  if (go) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // counts and register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            half_reg  <= 5'd15;
            seen_reg  <= '0;
            tgc_reg   <= '0;
            tat_reg   <= '0;
            wgc_reg   <= '0;
            wat_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                half_reg <= cfg_wr_data;
                seen_reg <= '0;
                tgc_reg  <= '0;
                tat_reg  <= '0;
                wgc_reg  <= '0;
                wat_reg  <= '0;
            end else if (go) begin
                if (last_reg) begin
                    seen_reg <= '0;
                    tgc_reg  <= '0;
                    tat_reg  <= '0;
                    wgc_reg  <= '0;
                    wat_reg  <= '0;
                end else begin
                    seen_reg <= n;
                    tgc_reg  <= tgc_reg + 32'(inc_gc);
                    tat_reg  <= tat_reg + 32'(inc_at);
                    wgc_reg  <= wgc_new;
                    wat_reg  <= wat_new;
                end
            end
        end
    end
endmodule

// File: rtl/swgc_back.sv
// swgc_back: takes jobs, divides for the levels, sends the repeated results
// depends on swgc_pkg and swgc_div
module swgc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_empty,
    input  swgc_pkg::job_t job_in,
    output logic           job_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_data,
    output logic           out_last
);
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_LDIV = 4'b0010,
        B_WDIV = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t        state_reg;
    swgc_pkg::job_t job_reg;
    logic [15:0]    level_reg, whole_reg;
    logic [5:0]     rep_reg;
    logic           div_start, div_done;
    logic [31:0]    div_num;
    logic [32:0]    div_den, win_sum, tot_sum;
    logic [15:0]    div_quo;

    assign win_sum = 33'(job_reg.win_gc) + 33'(job_reg.win_at);
    assign tot_sum = {1'b0, job_reg.tot_gc} + {1'b0, job_reg.tot_at};
    assign job_pop = (state_reg == B_IDLE) && !job_empty;

    // divider operands: window on pop, totals after the window level of a last job
    always_comb begin
        if (state_reg == B_IDLE) begin
            div_start = !job_empty;
            div_num   = 32'(job_in.win_gc);
            div_den   = 33'(job_in.win_gc) + 33'(job_in.win_at);
        end else begin
            div_start = (state_reg == B_LDIV) && div_done && job_reg.last;
            div_num   = job_reg.tot_gc;
            div_den   = tot_sum;
        end
    end

    swgc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign out_valid = (state_reg == B_OUT);
    assign out_last  = job_reg.last && (rep_reg == 6'd1);
    assign out_data  = {(out_last ? whole_reg : 16'd0), level_reg};

    // job sequencing
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job_in;
        end
        if (state_reg == B_LDIV && div_done) begin
            level_reg <= (win_sum == '0) ? swgc_pkg::HALF_LEVEL : div_quo;
        end
        if (state_reg == B_WDIV && div_done) begin
            whole_reg <= (tot_sum == '0) ? swgc_pkg::HALF_LEVEL : div_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            rep_reg   <= '0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (!job_empty) begin
                        state_reg <= B_LDIV;
                        rep_reg   <= job_in.rep;
                    end
                end
                B_LDIV: begin
                    if (div_done) state_reg <= job_reg.last ? B_WDIV : B_OUT;
                end
                B_WDIV: begin
                    if (div_done) state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (out_ready) begin
                        rep_reg <= rep_reg - 1'b1;
                        if (rep_reg == 6'd1) state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/sliding_window_gc_fraction_unit.sv
// sliding_window_gc_fraction_unit: top level, front, job queue and back
// sequence: the front registers a base and updates its counts; the back divides
// for the window level and, on the final base, for the whole-sequence fraction,
// then sends each result beat. The front takes no new base while in its update
// state, which waits on a full queue; the back pops no job until the last is sent
// reset: aresetn synchronous active low; half_window returns to 15, counts clear
module sliding_window_gc_fraction_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // base
    input  logic        s_tlast,   // last_base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // level [15:0], whole_level [31:16]
    output logic        m_tlast    // last_result
);
    swgc_pkg::job_t push_job, pop_job;
    logic           job_push, job_full, job_pop, job_empty;

    // front: classification and window counts
    swgc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_base     (s_tdata),
        .in_last     (s_tlast),
        .job_push    (job_push),
        .job         (push_job),
        .job_full    (job_full)
    );

    // job queue
    swgc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (push_job),
        .full    (job_full),
        .pop     (job_pop),
        .dout    (pop_job),
        .empty   (job_empty)
    );

    // back: divisions and result beats
    swgc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_empty (job_empty),
        .job_in    (pop_job),
        .job_pop   (job_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    // no job is pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !job_full) else $error("job queue overflow");

    // a level never exceeds one
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= 16'd32768)) else $error("level out of range");

    // whole-sequence fraction only on the final beat
    a_whole_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[31:16] == 16'd0))
        else $error("whole level on non-final beat");
`endif
endmodule
